[rtl/core/c8_pkg.sv]
// Shared types, constants and sizes of the CHIP-8 execute core.
// Used by every module in rtl/core; depends on nothing.
package c8_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int MEM_BYTES     = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);
    localparam int PIX_W         = X_W + Y_W;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int MEM_AW        = $clog2(MEM_BYTES);

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] OP_CLS  = 8'hE0;
    localparam logic [7:0] OP_RET  = 8'hEE;
    localparam logic [7:0] OP_SKP  = 8'h9E;
    localparam logic [7:0] OP_SKNP = 8'hA1;
    localparam logic [7:0] OP_GDLY = 8'h07;
    localparam logic [7:0] OP_WKEY = 8'h0A;
    localparam logic [7:0] OP_SDLY = 8'h15;
    localparam logic [7:0] OP_SSND = 8'h18;
    localparam logic [7:0] OP_ADDI = 8'h1E;
    localparam logic [7:0] OP_FONT = 8'h29;
    localparam logic [7:0] OP_BCD  = 8'h33;
    localparam logic [7:0] OP_DUMP = 8'h55;
    localparam logic [7:0] OP_LOAD = 8'h65;

    localparam logic [3:0] AT_MOV = 4'h0;
    localparam logic [3:0] AT_OR  = 4'h1;
    localparam logic [3:0] AT_AND = 4'h2;
    localparam logic [3:0] AT_XOR = 4'h3;
    localparam logic [3:0] AT_ADD = 4'h4;
    localparam logic [3:0] AT_SUB = 4'h5;
    localparam logic [3:0] AT_SHR = 4'h6;
    localparam logic [3:0] AT_SBN = 4'h7;
    localparam logic [3:0] AT_SHL = 4'hE;

    typedef enum logic [2:0] {
        ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] addr;
        logic             wdata;
    } fb_req_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] opcode;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
    } c8_in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  read_data;
        logic        draw_pending;
        logic        key_waiting;
        logic        halted;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
    } c8_out_t;

endpackage

[rtl/core/c8_alu.sv]
// Shared 8-bit arithmetic, logic and shift unit with flag output.
// Depends on c8_pkg.
module c8_alu (
    input  c8_pkg::alu_req_t req,
    output logic [7:0]       res,
    output logic             flag
);
    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, req.a} + {1'b0, req.b};

    always_comb begin
        res  = req.b;
        flag = 1'b0;
        unique case (req.op)
            ALU_PASS: res = req.b;
            ALU_OR:   res = req.a | req.b;
            ALU_AND:  res = req.a & req.b;
            ALU_XOR:  res = req.a ^ req.b;
            ALU_ADD: begin
                res  = sum[7:0];
                flag = sum[8];
            end
            ALU_SUB: begin
                res  = req.a - req.b;
                flag = (req.a >= req.b);
            end
            ALU_SHR: begin
                res  = {1'b0, req.a[7:1]};
                flag = req.a[0];
            end
            ALU_SHL: begin
                res  = {req.a[6:0], 1'b0};
                flag = req.a[7];
            end
            default: res = req.b;
        endcase
    end

endmodule

[rtl/core/c8_fb.sv]
// Monochrome frame buffer: one-bit memory with one port and registered read.
// Depends on c8_pkg.
module c8_fb (
    input  logic            aclk,
    input  c8_pkg::fb_req_t req,
    output logic            rdata
);
    import c8_pkg::*;

    logic mem [PIXELS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

[rtl/core/chip8_instruction_execute_core.sv]
// CHIP-8 execute core: one command word in, one status word out per command.
// Depends on c8_pkg, c8_alu and c8_fb.
// After reset the core sweeps the frame buffer clear, one pixel a cycle, before
// it takes its first word. A screen clear, a sprite draw, BCD, a register dump
// or load and a key scan each run as a sequence of steps, since every step
// goes through the one ALU, register read port, memory port and frame buffer
// port. A finished word waits in the output register while the next word is
// taken.
module chip8_instruction_execute_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  c8_pkg::c8_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output c8_pkg::c8_out_t m_data
);
    import c8_pkg::*;

    typedef enum logic [18:0] {
        S_INIT  = 19'h00001,
        S_IDLE  = 19'h00002,
        S_DISP  = 19'h00004,
        S_PIXRD = 19'h00008,
        S_KEY   = 19'h00010,
        S_RDX   = 19'h00020,
        S_RDY   = 19'h00040,
        S_EXEC  = 19'h00080,
        S_FLAG  = 19'h00100,
        S_CLR   = 19'h00200,
        S_DMEM  = 19'h00400,
        S_DROW  = 19'h00800,
        S_DPIX  = 19'h01000,
        S_DWR   = 19'h02000,
        S_BCD   = 19'h04000,
        S_DUMP  = 19'h08000,
        S_LRD   = 19'h10000,
        S_LWR   = 19'h20000,
        S_DONE  = 19'h40000
    } state_t;

    state_t            state_reg, state_next;
    c8_in_t            in_reg, in_next;
    logic [7:0]        vx_reg, vx_next, vy_reg, vy_next;
    logic [11:0]       pc_reg, pc_next;
    logic [15:0]       idx_reg, idx_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [7:0]        delay_reg, delay_next, sound_reg, sound_next;
    logic              wait_reg, wait_next, draw_reg, draw_next, halt_reg, halt_next;
    logic [15:0]       saved_reg, saved_next;
    logic              flag_reg, flag_next, coll_reg, coll_next;
    logic [7:0]        row_reg, row_next, acc_reg, acc_next;
    logic [3:0]        line_reg, line_next, cnt_reg, cnt_next, dig_reg, dig_next;
    logic [2:0]        bit_reg, bit_next;
    logic [1:0]        phase_reg, phase_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              rd_reg, rd_next;
    logic              m_valid_reg;
    c8_out_t           m_data_reg;

    logic [7:0]        rf [16];
    logic [11:0]       stack [STACK_DEPTH];
    logic [7:0]        mem [MEM_BYTES];
    logic [7:0]        mem_rdata_reg;

    logic              rf_we, stack_we, mem_we;
    logic [3:0]        rf_waddr, rf_raddr;
    logic [7:0]        rf_wdata, rf_rdata, mem_wdata;
    logic [MEM_AW-1:0] mem_addr;
    logic [3:0]        mem_ofs;
    alu_req_t          alu_req;
    logic [7:0]        alu_res;
    logic              alu_flag;
    fb_req_t           fb_req;
    logic              fb_rdata;

    logic [3:0]        op_hi, op_x, op_y, op_n;
    logic [7:0]        op_lo;
    logic [7:0]        px_sum, py_sum;
    logic [PIX_W-1:0]  pix_addr;
    logic              eq;
    logic [11:0]       pc_inc;

    c8_alu u_alu (
        .req  (alu_req),
        .res  (alu_res),
        .flag (alu_flag)
    );

    c8_fb u_fb (
        .aclk  (aclk),
        .req   (fb_req),
        .rdata (fb_rdata)
    );

    assign op_hi    = in_reg.opcode[15:12];
    assign op_x     = in_reg.opcode[11:8];
    assign op_y     = in_reg.opcode[7:4];
    assign op_n     = in_reg.opcode[3:0];
    assign op_lo    = in_reg.opcode[7:0];
    assign px_sum   = vx_reg + 8'(bit_reg);
    assign py_sum   = vy_reg + 8'(line_reg);
    assign pix_addr = {py_sum[Y_W-1:0], px_sum[X_W-1:0]};
    assign eq       = (alu_res == 8'd0);
    assign pc_inc   = pc_reg + 12'd2;
    assign rf_rdata = rf[rf_raddr];
    assign mem_addr = (state_reg == S_DISP) ? in_reg.address[MEM_AW-1:0]
                                            : idx_reg[MEM_AW-1:0] + MEM_AW'(mem_ofs);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = vx_reg;
        alu_req.b  = vy_reg;
        if (state_reg == S_BCD) begin
            alu_req.a = acc_reg;
            alu_req.b = (phase_reg == 2'd0) ? 8'd100 : 8'd10;
        end else begin
            case (op_hi)
                4'h3, 4'h4: alu_req.b = op_lo;
                4'h7: begin
                    alu_req.op = ALU_ADD;
                    alu_req.b  = op_lo;
                end
                4'h8: begin
                    case (op_n)
                        AT_MOV: alu_req.op = ALU_PASS;
                        AT_OR:  alu_req.op = ALU_OR;
                        AT_AND: alu_req.op = ALU_AND;
                        AT_XOR: alu_req.op = ALU_XOR;
                        AT_ADD: alu_req.op = ALU_ADD;
                        AT_SHR: alu_req.op = ALU_SHR;
                        AT_SHL: alu_req.op = ALU_SHL;
                        AT_SBN: begin
                            alu_req.a = vy_reg;
                            alu_req.b = vx_reg;
                        end
                        default: alu_req.op = ALU_SUB;
                    endcase
                end
                default: alu_req.op = ALU_SUB;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        in_next    = in_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        wait_next  = wait_reg;
        draw_next  = draw_reg;
        halt_next  = halt_reg;
        saved_next = saved_reg;
        flag_next  = flag_reg;
        coll_next  = coll_reg;
        row_next   = row_reg;
        acc_next   = acc_reg;
        line_next  = line_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        pix_next   = pix_reg;
        rd_next    = rd_reg;
        rf_we      = 1'b0;
        rf_waddr   = op_x;
        rf_wdata   = alu_res;
        rf_raddr   = op_x;
        stack_we   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = in_reg.write_byte;
        mem_ofs    = 4'd0;
        fb_req.we    = 1'b0;
        fb_req.addr  = pix_addr;
        fb_req.wdata = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLR: begin
                fb_req.we   = 1'b1;
                fb_req.addr = pix_reg;
                pix_next    = pix_reg + 1'b1;
                if (32'(pix_reg) == PIXELS - 1) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                rd_next     = 1'b0;
                fb_req.addr = PIX_W'(in_reg.address);
                state_next  = S_DONE;
                if (in_reg.cmd == CMD_WRITE) begin
                    mem_we = 1'b1;
                end else if (in_reg.cmd == CMD_READ) begin
                    state_next = S_PIXRD;
                end else if (in_reg.cmd == CMD_EXEC && !halt_reg) begin
                    draw_next  = 1'b0;
                    cnt_next   = 4'd0;
                    state_next = wait_reg ? S_KEY : S_RDX;
                end
            end
            S_PIXRD: begin
                rd_next    = fb_rdata && (32'(in_reg.address) < PIXELS);
                state_next = S_DONE;
            end
            S_KEY: begin
                rf_wdata = 8'(cnt_reg);
                if (!saved_reg[cnt_reg] && in_reg.keys_down[cnt_reg]) begin
                    rf_we      = 1'b1;
                    wait_next  = 1'b0;
                    pc_next    = pc_inc;
                    state_next = S_DONE;
                end else begin
                    saved_next[cnt_reg] = in_reg.keys_down[cnt_reg];
                    cnt_next            = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDX: begin
                rf_raddr   = (op_hi == 4'hB) ? 4'd0 : op_x;
                vx_next    = rf_rdata;
                state_next = S_RDY;
            end
            S_RDY: begin
                rf_raddr   = op_y;
                vy_next    = rf_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                pc_next    = pc_inc;
                case (op_hi)
                    4'h0: begin
                        if (in_reg.opcode == 16'(OP_CLS)) begin
                            draw_next  = 1'b1;
                            pix_next   = '0;
                            state_next = S_CLR;
                        end else if (in_reg.opcode == 16'(OP_RET)) begin
                            pc_next = stack[sp_reg] + 12'd2;
                            sp_next = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
                        end
                    end
                    4'h1: pc_next = in_reg.opcode[11:0];
                    4'h2: begin
                        sp_next  = (32'(sp_reg) == STACK_DEPTH - 1) ? '0 : sp_reg + 1'b1;
                        stack_we = 1'b1;
                        pc_next  = in_reg.opcode[11:0];
                    end
                    4'h3, 4'h5: if (eq) pc_next = pc_reg + 12'd4;
                    4'h4, 4'h9: if (!eq) pc_next = pc_reg + 12'd4;
                    4'h6: begin
                        rf_we    = 1'b1;
                        rf_wdata = op_lo;
                    end
                    4'h7: rf_we = 1'b1;
                    4'h8: begin
                        if (op_n <= AT_SBN || op_n == AT_SHL) begin
                            rf_we = 1'b1;
                        end
                        if ((op_n >= AT_ADD && op_n <= AT_SBN) || op_n == AT_SHL) begin
                            flag_next  = alu_flag;
                            state_next = S_FLAG;
                        end
                    end
                    4'hA: idx_next = {4'd0, in_reg.opcode[11:0]};
                    4'hB: pc_next = vx_reg + in_reg.opcode[11:0];
                    4'hC: begin
                        rf_we    = 1'b1;
                        rf_wdata = in_reg.random_byte & op_lo;
                    end
                    4'hD: begin
                        line_next  = 4'd0;
                        coll_next  = 1'b0;
                        state_next = S_DMEM;
                    end
                    4'hE: begin
                        if (op_lo == OP_SKP) begin
                            if (vx_reg < 8'd16 && in_reg.keys_down[vx_reg[3:0]]) begin
                                pc_next = pc_reg + 12'd4;
                            end
                        end else if (op_lo == OP_SKNP) begin
                            if (!(vx_reg < 8'd16 && in_reg.keys_down[vx_reg[3:0]])) begin
                                pc_next = pc_reg + 12'd4;
                            end
                        end else begin
                            halt_next = 1'b1;
                            pc_next   = pc_reg;
                        end
                    end
                    default: begin
                        case (op_lo)
                            OP_GDLY: begin
                                rf_we    = 1'b1;
                                rf_wdata = delay_reg;
                            end
                            OP_WKEY: begin
                                saved_next = in_reg.keys_down;
                                wait_next  = 1'b1;
                                pc_next    = pc_reg;
                            end
                            OP_SDLY: delay_next = vx_reg;
                            OP_SSND: sound_next = vx_reg;
                            OP_ADDI: idx_next = idx_reg + 16'(vx_reg);
                            OP_FONT: idx_next = 16'({vx_reg, 2'b00}) + 16'(vx_reg);
                            OP_BCD: begin
                                acc_next   = vx_reg;
                                dig_next   = 4'd0;
                                phase_next = 2'd0;
                                state_next = S_BCD;
                            end
                            OP_DUMP: state_next = S_DUMP;
                            OP_LOAD: state_next = S_LRD;
                            default: begin
                                halt_next = 1'b1;
                                pc_next   = pc_reg;
                            end
                        endcase
                    end
                endcase
            end
            S_FLAG: begin
                rf_we      = 1'b1;
                rf_waddr   = 4'hF;
                rf_wdata   = {7'd0, flag_reg};
                state_next = S_DONE;
            end
            S_DMEM: begin
                mem_ofs = line_reg;
                if (line_reg == op_n) begin
                    flag_next  = coll_reg;
                    draw_next  = 1'b1;
                    state_next = S_FLAG;
                end else begin
                    state_next = S_DROW;
                end
            end
            S_DROW: begin
                row_next   = mem_rdata_reg;
                bit_next   = 3'd0;
                state_next = S_DPIX;
            end
            S_DPIX, S_DWR: begin
                if (state_reg == S_DWR) begin
                    fb_req.we    = 1'b1;
                    fb_req.wdata = !fb_rdata;
                    coll_next    = coll_reg | fb_rdata;
                end
                if (state_reg == S_DPIX && row_reg[3'd7 - bit_reg]) begin
                    state_next = S_DWR;
                end else if (bit_reg == 3'd7) begin
                    line_next  = line_reg + 4'd1;
                    state_next = S_DMEM;
                end else begin
                    bit_next   = bit_reg + 3'd1;
                    state_next = S_DPIX;
                end
            end
            S_BCD: begin
                mem_ofs = 4'(phase_reg);
                if (phase_reg == 2'd2) begin
                    mem_we     = 1'b1;
                    mem_wdata  = acc_reg;
                    state_next = S_DONE;
                end else if (alu_flag) begin
                    acc_next = alu_res;
                    dig_next = dig_reg + 4'd1;
                end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = 8'(dig_reg);
                    dig_next   = 4'd0;
                    phase_next = phase_reg + 2'd1;
                end
            end
            S_DUMP: begin
                rf_raddr  = cnt_reg;
                mem_ofs   = cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = rf_rdata;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == op_x) begin
                    idx_next   = idx_reg + 16'(op_x) + 16'd1;
                    state_next = S_DONE;
                end
            end
            S_LRD: begin
                mem_ofs    = cnt_reg;
                state_next = S_LWR;
            end
            S_LWR: begin
                rf_we      = 1'b1;
                rf_waddr   = cnt_reg;
                rf_wdata   = mem_rdata_reg;
                cnt_next   = cnt_reg + 4'd1;
                state_next = S_LRD;
                if (cnt_reg == op_x) begin
                    idx_next   = idx_reg + 16'(op_x) + 16'd1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            pc_reg      <= 12'h200;
            idx_reg     <= '0;
            sp_reg      <= '0;
            delay_reg   <= '0;
            sound_reg   <= '0;
            wait_reg    <= 1'b0;
            draw_reg    <= 1'b0;
            halt_reg    <= 1'b0;
            saved_reg   <= '0;
            pix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            wait_reg  <= wait_next;
            draw_reg  <= draw_next;
            halt_reg  <= halt_next;
            saved_reg <= saved_next;
            pix_reg   <= pix_next;
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        in_reg    <= in_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        flag_reg  <= flag_next;
        coll_reg  <= coll_next;
        row_reg   <= row_next;
        acc_reg   <= acc_next;
        line_reg  <= line_next;
        cnt_reg   <= cnt_next;
        dig_reg   <= dig_next;
        bit_reg   <= bit_next;
        phase_reg <= phase_next;
        rd_reg    <= rd_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.program_counter <= pc_reg;
            m_data_reg.index_value     <= idx_reg;
            m_data_reg.read_data       <= 8'(rd_reg);
            m_data_reg.draw_pending    <= draw_reg;
            m_data_reg.key_waiting     <= wait_reg;
            m_data_reg.halted          <= halt_reg;
            m_data_reg.delay_value     <= delay_reg;
            m_data_reg.sound_value     <= sound_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                rf[i] <= '0;
            end
        end else if (rf_we) begin
            rf[rf_waddr] <= rf_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack[sp_next] <= pc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Core took a second word while busy.");
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("Halt flag cleared without reset.");
    a_fb_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fb_req.we |-> (state_reg == S_INIT || state_reg == S_CLR || state_reg == S_DWR))
        else $error("Frame buffer written outside clear or draw.");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !rf_we && !mem_we && !stack_we)
        else $error("State written while idle.");

endmodule

[dv/chip8_instruction_execute_core_tb.sv]
// Testbench for chip8_instruction_execute_core: directed table, random words, then a closing table.
// Every status word is checked against an in-bench CHIP-8 machine model or a row's fixed status.
// Depends on c8_pkg and the core RTL only.
module chip8_instruction_execute_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c8_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int IDLE_LIMIT = 12000;
    localparam int RANDOM_WORDS = 850;

    typedef enum logic [3:0] {
        GRP_SYS, GRP_JP, GRP_CALL, GRP_SE, GRP_SNE, GRP_SER, GRP_LD, GRP_ADD,
        GRP_ALU, GRP_SNER, GRP_LDI, GRP_JPV, GRP_RND, GRP_DRW, GRP_KEY, GRP_MISC
    } op_group_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] opcode;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [15:0] keys;
        logic [7:0]  rnd;
        bit          typed;
        c8_out_t     status;
    } row_t;

    localparam c8_out_t AFTER_RESET = '{12'h200, 16'h0, 8'h0, 1'b0, 1'b0, 1'b0, 8'h0, 8'h0};

    row_t opening [38] = '{
        '{CMD_READ,  16'h0000, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, AFTER_RESET},
        '{CMD_NONE,  16'hFFFF, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, AFTER_RESET},
        '{CMD_EXEC,  16'h60FF, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h61FF, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h8014, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h8015, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h8016, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h801E, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h8017, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h8F14, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h800F, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hC0A5, 12'h000, 8'h00, 16'h0000, 8'h5A, 1'b0, '0},
        '{CMD_WRITE, 16'h0000, 12'hFFE, 8'hFF, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_WRITE, 16'h0000, 12'hFFF, 8'h81, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_WRITE, 16'h0000, 12'h000, 8'hC3, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h603E, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h611E, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hAFFE, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hD013, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_READ,  16'h0000, 12'h7BE, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hD013, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_READ,  16'h0000, 12'h800, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF029, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF033, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF155, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF165, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF015, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF118, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF207, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h6020, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hE09E, 12'h000, 8'h00, 16'hFFFF, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hE0A1, 12'h000, 8'h00, 16'hFFFF, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h2ABC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h00EE, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h1FFE, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h3020, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hF30A, 12'h000, 8'h00, 16'h0001, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h0500, 12'h000, 8'h00, 16'h0003, 8'h00, 1'b0, '0}
    };

    row_t closing [6] = '{
        '{CMD_EXEC,  16'h00E0, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hB010, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'hE0FF, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_EXEC,  16'h6077, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_WRITE, 16'h0000, 12'h010, 8'hAA, 16'h0000, 8'h00, 1'b0, '0},
        '{CMD_READ,  16'h0000, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b0, '0}
    };

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    c8_in_t  s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    c8_out_t m_data;

    chip8_instruction_execute_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Machine state as the core should hold it.
    logic [7:0]  v_reg [16];
    logic [11:0] pc;
    logic [15:0] index_i;
    logic [3:0]  sp;
    logic [11:0] call_stack [16];
    bit          stack_set [16];
    logic [7:0]  memory [MEM_BYTES];
    bit          mem_set [MEM_BYTES];
    bit          pixels [PIXELS];
    logic [7:0]  delay_t, sound_t;
    bit          waiting, drawn, halted;
    logic [15:0] saved_keys;

    c8_out_t status_q [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_request = 1'b0;
    int      hold_count = 0;
    int      idle_cycles = 0;

    task automatic step_pc();
        pc = pc + 12'd2;
    endtask

    task automatic run_alu(input logic [3:0] x, input logic [3:0] y, input logic [3:0] kind);
        logic [7:0] a, b, res;
        logic [8:0] sum;
        int flag;
        a = v_reg[x];
        b = v_reg[y];
        res = a;
        flag = -1;
        sum = {1'b0, a} + {1'b0, b};
        case (kind)
            AT_MOV: res = b;
            AT_OR:  res = a | b;
            AT_AND: res = a & b;
            AT_XOR: res = a ^ b;
            AT_ADD: begin res = sum[7:0]; flag = sum[8]; end
            AT_SUB: begin res = a - b; flag = (a >= b); end
            AT_SHR: begin res = a >> 1; flag = a[0]; end
            AT_SBN: begin res = b - a; flag = (b >= a); end
            AT_SHL: begin res = a << 1; flag = a[7]; end
            default: ;
        endcase
        v_reg[x] = res;
        if (flag >= 0) v_reg[15] = flag[7:0];
    endtask

    task automatic draw_sprite(input logic [3:0] x, input logic [3:0] y, input logic [3:0] rows);
        int px, py, p;
        logic [7:0] line_bits;
        logic [11:0] at;
        px = v_reg[x];
        py = v_reg[y];
        v_reg[15] = 8'd0;
        for (int line = 0; line < rows; line++) begin
            at = index_i[11:0] + 12'(line);
            line_bits = memory[at];
            for (int b = 0; b < 8; b++) begin
                if (line_bits[7-b]) begin
                    p = ((px + b) % SCREEN_WIDTH) + ((py + line) % SCREEN_HEIGHT) * SCREEN_WIDTH;
                    if (pixels[p]) v_reg[15] = 8'd1;
                    pixels[p] = ~pixels[p];
                end
            end
        end
        drawn = 1'b1;
    endtask

    task automatic run_opcode(input logic [15:0] op, input logic [15:0] keys, input logic [7:0] rnd);
        logic [3:0] x, y, n;
        logic [7:0] lo, vx;
        logic [11:0] nnn, at;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        lo = op[7:0];
        nnn = op[11:0];
        vx = v_reg[x];
        case (op_group_t'(op[15:12]))
            GRP_SYS: begin
                if (op[11:0] == {4'h0, OP_CLS}) begin
                    for (int i = 0; i < PIXELS; i++) pixels[i] = 1'b0;
                    drawn = 1'b1;
                end else if (op[11:0] == {4'h0, OP_RET}) begin
                    pc = call_stack[sp];
                    sp = sp - 4'd1;
                end
                step_pc();
            end
            GRP_JP:   pc = nnn;
            GRP_CALL: begin
                sp = sp + 4'd1;
                call_stack[sp] = pc;
                stack_set[sp] = 1'b1;
                pc = nnn;
            end
            GRP_SE:   begin if (vx == lo) step_pc(); step_pc(); end
            GRP_SNE:  begin if (vx != lo) step_pc(); step_pc(); end
            GRP_SER:  begin if (vx == v_reg[y]) step_pc(); step_pc(); end
            GRP_LD:   begin v_reg[x] = lo; step_pc(); end
            GRP_ADD:  begin v_reg[x] = vx + lo; step_pc(); end
            GRP_ALU:  begin run_alu(x, y, n); step_pc(); end
            GRP_SNER: begin if (vx != v_reg[y]) step_pc(); step_pc(); end
            GRP_LDI:  begin index_i = {4'h0, nnn}; step_pc(); end
            GRP_JPV:  pc = v_reg[0] + nnn;
            GRP_RND:  begin v_reg[x] = rnd & lo; step_pc(); end
            GRP_DRW:  begin draw_sprite(x, y, n); step_pc(); end
            GRP_KEY: begin
                if (lo == OP_SKP) begin
                    if (vx < 16 && keys[vx[3:0]]) step_pc();
                    step_pc();
                end else if (lo == OP_SKNP) begin
                    if (!(vx < 16 && keys[vx[3:0]])) step_pc();
                    step_pc();
                end else begin
                    halted = 1'b1;
                end
            end
            default: begin
                case (lo)
                    OP_GDLY: begin v_reg[x] = delay_t; step_pc(); end
                    OP_WKEY: begin saved_keys = keys; waiting = 1'b1; end
                    OP_SDLY: begin delay_t = vx; step_pc(); end
                    OP_SSND: begin sound_t = vx; step_pc(); end
                    OP_ADDI: begin index_i = index_i + vx; step_pc(); end
                    OP_FONT: begin index_i = 16'(vx) * 16'd5; step_pc(); end
                    OP_BCD: begin
                        at = index_i[11:0];
                        memory[at] = vx / 100;
                        memory[at + 12'd1] = (vx / 10) % 10;
                        memory[at + 12'd2] = vx % 10;
                        for (int i = 0; i < 3; i++) mem_set[at + 12'(i)] = 1'b1;
                        step_pc();
                    end
                    OP_DUMP: begin
                        for (int i = 0; i <= x; i++) begin
                            at = index_i[11:0] + 12'(i);
                            memory[at] = v_reg[i];
                            mem_set[at] = 1'b1;
                        end
                        index_i = index_i + 16'(x) + 16'd1;
                        step_pc();
                    end
                    OP_LOAD: begin
                        for (int i = 0; i <= x; i++) v_reg[i] = memory[index_i[11:0] + 12'(i)];
                        index_i = index_i + 16'(x) + 16'd1;
                        step_pc();
                    end
                    default: halted = 1'b1;
                endcase
            end
        endcase
    endtask

    task automatic chip8_step(input c8_in_t w, output c8_out_t st);
        logic [7:0] rd;
        rd = 8'd0;
        case (w.cmd)
            CMD_EXEC: begin
                if (!halted) begin
                    drawn = 1'b0;
                    if (waiting) begin
                        for (int i = 0; i < 16; i++) begin
                            if (!saved_keys[i] && w.keys_down[i]) begin
                                waiting = 1'b0;
                                v_reg[w.opcode[11:8]] = 8'(i);
                                step_pc();
                                break;
                            end
                            saved_keys[i] = w.keys_down[i];
                        end
                    end else begin
                        run_opcode(w.opcode, w.keys_down, w.random_byte);
                    end
                end
            end
            CMD_WRITE: begin
                memory[w.address] = w.write_byte;
                mem_set[w.address] = 1'b1;
            end
            CMD_READ: if (w.address < PIXELS) rd = {7'd0, pixels[w.address]};
            default: ;
        endcase
        st = '{pc, index_i, rd, drawn, waiting, halted, delay_t, sound_t};
    endtask

    task automatic send_word(input c8_in_t w, input bit typed, input c8_out_t typed_status);
        c8_out_t st;
        chip8_step(w, st);
        status_q.push_back(typed ? typed_status : st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_row(input row_t r);
        send_word('{r.cmd, r.opcode, r.address, r.write_byte, r.keys, r.rnd}, r.typed, r.status);
    endtask

    task automatic fill_memory(input logic [11:0] start, input int count);
        logic [11:0] at;
        for (int i = 0; i < count; i++) begin
            at = start + 12'(i);
            if (!mem_set[at])
                send_word('{CMD_WRITE, 16'h0, at, 8'($urandom), 16'h0, 8'h0}, 1'b0, '0);
        end
    endtask

    task automatic send_random();
        c8_in_t w;
        logic [7:0] misc_ops [11];
        int pick;
        misc_ops = '{OP_GDLY, OP_WKEY, OP_SDLY, OP_SSND, OP_ADDI, OP_FONT,
                     OP_BCD, OP_DUMP, OP_LOAD, OP_FONT, OP_ADDI};
        w = '{CMD_EXEC, 16'($urandom), 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom)};
        pick = $urandom_range(0, 99);
        if (pick < 8) w.cmd = CMD_WRITE;
        else if (pick < 18) w.cmd = CMD_READ;
        else if (pick < 20) w.cmd = CMD_NONE;
        if (w.cmd == CMD_EXEC && !waiting) begin
            case (op_group_t'(w.opcode[15:12]))
                GRP_SYS: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) w.opcode = {8'h00, OP_CLS};
                    else if (pick < 50) w.opcode = {8'h00, OP_RET};
                    if (w.opcode == {8'h00, OP_RET} && !stack_set[sp])
                        w.opcode[15:12] = GRP_CALL;
                end
                GRP_SE, GRP_SNE: if ($urandom_range(0, 1)) w.opcode[7:0] = v_reg[w.opcode[11:8]];
                GRP_ALU: if ($urandom_range(0, 9) != 0)
                    w.opcode[3:0] = ($urandom_range(0, 8) == 8) ? AT_SHL : 4'($urandom_range(0, 7));
                GRP_DRW: fill_memory(index_i[11:0], w.opcode[3:0]);
                GRP_KEY: w.opcode[7:0] = $urandom_range(0, 1) ? OP_SKP : OP_SKNP;
                GRP_MISC: begin
                    w.opcode[7:0] = misc_ops[$urandom_range(0, 10)];
                    if (w.opcode[7:0] == OP_LOAD)
                        fill_memory(index_i[11:0], int'(w.opcode[11:8]) + 1);
                end
                default: ;
            endcase
        end
        send_word(w, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        c8_out_t want;
        if (m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                errors++;
                $error("Status word arrived with none outstanding.");
            end else begin
                want = status_q.pop_front();
                check_field("program_counter", want.program_counter, m_data.program_counter);
                check_field("index_value", want.index_value, m_data.index_value);
                check_field("read_data", want.read_data, m_data.read_data);
                check_field("draw_pending", want.draw_pending, m_data.draw_pending);
                check_field("key_waiting", want.key_waiting, m_data.key_waiting);
                check_field("halted", want.halted, m_data.halted);
                check_field("delay_value", want.delay_value, m_data.delay_value);
                check_field("sound_value", want.sound_value, m_data.sound_value);
            end
        end
        if (hold_request && hold_count == 0) hold_count = 400;
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            v_reg[i] = 8'd0;
            call_stack[i] = 12'd0;
            stack_set[i] = 1'b0;
        end
        for (int i = 0; i < MEM_BYTES; i++) begin
            memory[i] = 8'd0;
            mem_set[i] = 1'b0;
        end
        for (int i = 0; i < PIXELS; i++) pixels[i] = 1'b0;
        pc = 12'h200;
        index_i = 16'd0;
        sp = 4'd0;
        delay_t = 8'd0;
        sound_t = 8'd0;
        waiting = 1'b0;
        drawn = 1'b0;
        halted = 1'b0;
        saved_keys = 16'd0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) send_row(opening[i]);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i < 200) begin send_idle_pct = 0; recv_stall_pct = 0; end
            else if (i < 400) begin send_idle_pct = 54; recv_stall_pct = 0; end
            else if (i < 600) begin send_idle_pct = 0; recv_stall_pct = 54; end
            else if (i < 750) begin send_idle_pct = 10; recv_stall_pct = 10; end
            else begin send_idle_pct = 0; recv_stall_pct = 0; end
            hold_request <= (i == 100);
            if (i == 300) begin
                s_valid <= 1'b0;
                while (status_q.size() != 0) @(posedge aclk);
            end
            send_random();
        end

        while (waiting)
            send_word('{CMD_EXEC, 16'h0, 12'h0, 8'h0, ~saved_keys, 8'h0}, 1'b0, '0);
        foreach (closing[i]) send_row(closing[i]);

        s_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/c8_pkg.sv
rtl/core/c8_alu.sv
rtl/core/c8_fb.sv
rtl/core/chip8_instruction_execute_core.sv
dv/chip8_instruction_execute_core_tb.sv
